// ----- rtl/core/humidity_routine_matcher_assert.svh -----
// ----------------------------------------------------------------------------
// humidity_routine_matcher assertion macros
// Shared concurrent assertion forms for the routine matcher checkers.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_ROUTINE_MATCHER_ASSERT_SVH
`define HUMIDITY_ROUTINE_MATCHER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define HRM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrm assertion failed");

// next-cycle implication, disabled in reset
`define HRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrm assertion failed");

`endif

// ----- rtl/core/hrm_pkg.sv -----
// ----------------------------------------------------------------------------
// hrm_pkg
// Types and codes shared by the routine matcher, its cells and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hrm_pkg;

  localparam logic [1:0] OP_EVAL  = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] CFG_TEMP_LOW  = 2'd0;
  localparam logic [1:0] CFG_TEMP_HIGH = 2'd1;
  localparam logic [1:0] CFG_HUM_LOW   = 2'd2;
  localparam logic [1:0] CFG_HUM_HIGH  = 2'd3;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_DEHUM = 2'd1;
  localparam logic [1:0] KIND_HUM   = 2'd2;

  localparam logic [2:0] DAY_UNKNOWN = 3'd7;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [2:0]         weekday;
    logic [10:0]        minute_of_day;
    logic signed [11:0] temperature;
    logic [9:0]         humidity;
    logic               manual_on;
    logic [6:0]         day_mask;
    logic [10:0]        start_minute;
    logic [10:0]        end_minute;
    logic               dry_mode;
    logic [9:0]         threshold;
  } in_t;

  typedef struct packed {
    logic       accepted;
    logic       device_on;
    logic [1:0] device_kind;
    logic       matched;
    logic [2:0] match_index;
  } out_t;

  typedef struct packed {
    logic [6:0]  day_mask;
    logic [10:0] start_minute;
    logic [10:0] end_minute;
    logic        dry_mode;
    logic [9:0]  threshold;
  } entry_t;

  typedef struct packed {
    logic [2:0]  weekday;
    logic [10:0] minute;
    logic [9:0]  humidity;
    logic        env_ok;
  } sample_t;

  typedef struct packed {
    logic       found;
    logic       dry;
    logic [2:0] index;
  } chain_t;

endpackage

`default_nettype wire

// ----- rtl/core/hrm_cell.sv -----
// ----------------------------------------------------------------------------
// hrm_cell
// One routine slot: stores its entry and tests it against the broadcast
// sample, passing the first-match result on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module hrm_cell
  import hrm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    wr_en,
  input  wire entry_t  wr_entry,
  input  wire logic    active,
  input  wire logic [2:0] slot_id,
  input  wire sample_t sample,
  input  wire chain_t  chain_in,
  output chain_t       chain_out
);

  entry_t entry_r;
  logic   day_ok;
  logic   win_ok;
  logic   cond_ok;
  logic   hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= wr_entry;
    end
  end

  always_comb begin
    day_ok = (sample.weekday != DAY_UNKNOWN) && entry_r.day_mask[sample.weekday];
    if (entry_r.start_minute <= entry_r.end_minute) begin
      win_ok = (sample.minute >= entry_r.start_minute) &&
               (sample.minute <= entry_r.end_minute);
    end else begin
      win_ok = (sample.minute >= entry_r.start_minute) ||
               (sample.minute <= entry_r.end_minute);
    end
    cond_ok = entry_r.dry_mode ? (sample.humidity > entry_r.threshold)
                               : (sample.humidity < entry_r.threshold);
    hit = active && day_ok && win_ok && cond_ok && sample.env_ok;

    chain_out = chain_in;
    if (!chain_in.found && hit) begin
      chain_out.found = 1'b1;
      chain_out.dry   = entry_r.dry_mode;
      chain_out.index = slot_id;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/humidity_routine_matcher.sv -----
// ----------------------------------------------------------------------------
// humidity_routine_matcher
// Routine table held in a row of cells; evaluates samples, appends and
// clears routines, one transaction per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
//  channel  direction  handshake        payload
//  in       input      in_valid/stall   in_data  (in_t)
//  out      output     out_valid/stall  out_data (out_t)
//  cfg      input      cfg_valid/ready  cfg_index, cfg_data
//
//  Each transaction passes combinationally through the cell row and its result
//  appears in the output register on the next cycle; one per cycle unless stalled.
//  The cells test in parallel; the first-match chain through them sets depth.
//  Reset empties the routine table (count to zero), zeroes the environment limits
//  and clears out_valid. A stalled result holds the output register and stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_routine_matcher
  import hrm_pkg::*;
#(
  parameter int unsigned ROUTINE_SLOTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  localparam int unsigned CW = $clog2(ROUTINE_SLOTS + 1);

  logic signed [11:0] temp_low_r;
  logic signed [11:0] temp_high_r;
  logic [9:0]         hum_low_r;
  logic [9:0]         hum_high_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  out_t               out_data_r;
  out_t               out_data_nxt;

  logic    accept;
  logic    not_full;
  logic    add_go;
  entry_t  wr_entry;
  sample_t sample;
  chain_t  chain [ROUTINE_SLOTS+1];

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign not_full  = count_r < CW'(ROUTINE_SLOTS);
  assign add_go    = accept && (in_data.opcode == OP_ADD) && not_full;

  assign wr_entry.day_mask     = in_data.day_mask;
  assign wr_entry.start_minute = in_data.start_minute;
  assign wr_entry.end_minute   = in_data.end_minute;
  assign wr_entry.dry_mode     = in_data.dry_mode;
  assign wr_entry.threshold    = in_data.threshold;

  assign sample.weekday  = in_data.weekday;
  assign sample.minute   = in_data.minute_of_day;
  assign sample.humidity = in_data.humidity;
  assign sample.env_ok   = ($signed(in_data.temperature) >= temp_low_r) &&
                           ($signed(in_data.temperature) <= temp_high_r) &&
                           (in_data.humidity >= hum_low_r) &&
                           (in_data.humidity <= hum_high_r);

  assign chain[0] = '0;

  for (genvar g = 0; g < ROUTINE_SLOTS; g++) begin : g_cell
    hrm_cell u_cell (
      .clk       (clk),
      .wr_en     (add_go && (count_r == CW'(g))),
      .wr_entry  (wr_entry),
      .active    (count_r > CW'(g)),
      .slot_id   (3'(g)),
      .sample    (sample),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (add_go) begin
      count_nxt = count_r + CW'(1);
    end else if (accept && (in_data.opcode == OP_CLEAR)) begin
      count_nxt = '0;
    end

    out_data_nxt = '0;
    out_data_nxt.accepted = 1'b1;
    case (in_data.opcode)
      OP_ADD: begin
        out_data_nxt.accepted = not_full;
      end
      OP_EVAL: begin
        if (chain[ROUTINE_SLOTS].found) begin
          out_data_nxt.matched     = 1'b1;
          out_data_nxt.match_index = chain[ROUTINE_SLOTS].index;
          out_data_nxt.device_on   = 1'b1;
          out_data_nxt.device_kind = chain[ROUTINE_SLOTS].dry ? KIND_DEHUM : KIND_HUM;
        end else begin
          out_data_nxt.device_on   = in_data.manual_on;
          out_data_nxt.device_kind = in_data.manual_on ? KIND_DEHUM : KIND_NONE;
        end
      end
      default: begin
      end
    endcase

    if (accept) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_low_r  <= '0;
      temp_high_r <= '0;
      hum_low_r   <= '0;
      hum_high_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TEMP_LOW:  temp_low_r  <= $signed(cfg_data);
          CFG_TEMP_HIGH: temp_high_r <= $signed(cfg_data);
          CFG_HUM_LOW:   hum_low_r   <= cfg_data[9:0];
          CFG_HUM_HIGH:  hum_high_r  <= cfg_data[9:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/hrm_checker.sv -----
// ----------------------------------------------------------------------------
// hrm_checker
// Port-level checks on the routine matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "humidity_routine_matcher_assert.svh"

module hrm_checker
  import hrm_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire out_t        out_data
);

  `HRM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `HRM_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, in_valid && !in_stall, out_valid)
  `HRM_ASSERT_NOW(a_no_match_index, clk, rst_n, out_valid && !out_data.matched, out_data.match_index == 3'd0)
  `HRM_ASSERT_NOW(a_match_drives_on, clk, rst_n, out_valid && out_data.matched, out_data.device_on && (out_data.device_kind != KIND_NONE))

endmodule

bind humidity_routine_matcher hrm_checker u_hrm_checker (.*);

`default_nettype wire
